@@ src/rrg_pkg.sv @@
// rrg_pkg: shared types, constants and helper functions of the rotated roi grid generator
// depends on nothing; imported by the response interface, the arithmetic unit and the top level
`default_nettype none

package rrg_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 18;
   localparam int DIV_BITS      = 30;
   localparam int XY_W          = 34;
   localparam int Z_W           = 32;
   localparam int ACC_W         = 36;
   localparam int TRIG_W        = 18;
   localparam int SIDE_W        = 13;
   localparam int IDX_W         = 12;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 17;
   localparam int MAG_W         = 28;

   localparam logic [SIDE_W-1:0] MAX_SIDE  = 13'd4096;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_COL = 3'd0,
      CSR_CENTER_ROW = 3'd1,
      CSR_ANGLE      = 3'd2,
      CSR_BOX_WIDTH  = 3'd3,
      CSR_BOX_DEPTH  = 3'd4,
      CSR_DIRECTION  = 3'd5,
      CSR_LINE_SKIP  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_TRIG,
      ST_MUL,
      ST_START,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_SKIP
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_CORDIC,
      OP_DIV,
      OP_MUL
   } unit_op_type;

   typedef struct packed {
      logic        neg;
      logic signed [14:0] r;
   } angle_type;

   // atan(2^-i) in 0.01 degree scaled by 2^16
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      unique case (i)
         5'd0:  v = 32'sd294912000;
         5'd1:  v = 32'sd174096719;
         5'd2:  v = 32'sd91987925;
         5'd3:  v = 32'sd46694507;
         5'd4:  v = 32'sd23437865;
         5'd5:  v = 32'sd11730358;
         5'd6:  v = 32'sd5866610;
         5'd7:  v = 32'sd2933484;
         5'd8:  v = 32'sd1466765;
         5'd9:  v = 32'sd733385;
         5'd10: v = 32'sd366693;
         5'd11: v = 32'sd183346;
         5'd12: v = 32'sd91673;
         5'd13: v = 32'sd45837;
         5'd14: v = 32'sd22918;
         5'd15: v = 32'sd11459;
         5'd16: v = 32'sd5730;
         5'd17: v = 32'sd2865;
         default: v = '0;
      endcase
      return v;
   endfunction

   // fold the angle into +-90 degrees, flagging a half-turn flip
   function automatic angle_type reduce_angle(input logic signed [16:0] a);
      logic signed [17:0] r;
      angle_type res;
      r = 18'(a);
      res.neg = 1'b0;
      if (r >= 18'sd36000) begin
         r = r - 18'sd36000;
      end else if (r <= -18'sd36000) begin
         r = r + 18'sd36000;
      end
      if (r >= 18'sd18000) begin
         r = r - 18'sd36000;
      end else if (r < -18'sd18000) begin
         r = r + 18'sd36000;
      end
      if (r > 18'sd9000) begin
         r = r - 18'sd18000;
         res.neg = 1'b1;
      end else if (r < -18'sd9000) begin
         r = r + 18'sd18000;
         res.neg = 1'b1;
      end
      res.r = r[14:0];
      return res;
   endfunction

   // round q30 cordic output to q16 with clamp to +-1.0 and optional flip
   function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v,
                                                          input logic neg);
      logic signed [XY_W-1:0] t;
      logic signed [19:0] s;
      logic signed [TRIG_W-1:0] c;
      t = v + 34'sd8192;
      s = t[XY_W-1:14];
      if (s > 20'sd65536) begin
         c = 18'sd65536;
      end else if (s < -20'sd65536) begin
         c = -18'sd65536;
      end else begin
         c = s[TRIG_W-1:0];
      end
      return neg ? -c : c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/rrg_if.sv @@
// rrg_if: valid/ready channel interfaces for the request and response sides
// depends on rrg_pkg for field widths
`default_nettype none

interface rrg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface rrg_rsp_if
   import rrg_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [31:0]      point_x;
   logic signed [31:0]      point_y;
   logic [IDX_W-1:0]        line_index;
   logic [IDX_W-1:0]        point_index;
   logic                    end_of_line;
   logic                    last;
   logic                    status;

   modport source (output valid, output point_x, output point_y, output line_index,
                   output point_index, output end_of_line, output last, output status,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input line_index,
                   input point_index, input end_of_line, input last, input status,
                   output ready);
endinterface

`default_nettype wire

@@ src/rotated_roi_grid_point_generator.sv @@
// rotated_roi_grid_point_generator: setup of a rotated roi sampling grid and point walk
// depends on rrg_pkg, rrg_if and rrg_unit
// restart with a valid configuration: busy after the accepting edge for the cordic rotation,
//   rounding, 4 multiplies, corner, 4 divides and 2 multiplies; all of it through the one rrg_unit
// advance ticks: one transaction per cycle unless the response is held, result in the cycle after acceptance
// reset (synchronous, active high): configuration and control registers back to their defaults, walk idle, no response
`default_nettype none

module rotated_roi_grid_point_generator
   import rrg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   rrg_req_if.sink                    req_chan,
   rrg_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      unit_op_type op;
      logic        ready;
   } ctrl_type;

   // configuration registers
   logic signed [14:0] center_col_ff;
   logic signed [14:0] center_row_ff;
   logic signed [16:0] angle_ff;
   logic [SIDE_W-1:0]  box_width_ff;
   logic [SIDE_W-1:0]  box_depth_ff;
   logic               direction_ff;
   logic [SIDE_W-1:0]  line_skip_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [4:0] iter_ff;
   logic [1:0] k_ff;
   ctrl_type   ctrl;

   // setup datapath
   logic signed [XY_W-1:0]   x_ff, y_ff;
   logic signed [Z_W-1:0]    z_ff;
   logic                     neg_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic [MAG_W-1:0]         mag_ff [4];
   logic [DIV_BITS-1:0]      dn_ff;
   logic [DIV_BITS-1:0]      q_ff;
   logic [13:0]              rem_ff;
   logic [13:0]              dd_ff;
   logic signed [TRIG_W-1:0] step_ff [4];
   logic signed [31:0]       skrs_x_ff, skrs_y_ff;

   // walk state
   logic signed [ACC_W-1:0] base_x_ff, base_y_ff;
   logic signed [ACC_W-1:0] cur_x_ff, cur_y_ff;
   logic [IDX_W-1:0]        lc_ff, pc_ff;
   logic                    active_ff;
   logic [SIDE_W-1:0]       walk_w_ff, walk_d_ff, walk_skip_ff;
   logic                    dir_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [IDX_W-1:0]   rsp_line_ff, rsp_point_ff;
   logic               rsp_eol_ff, rsp_last_ff, rsp_status_ff;

   // unit connections
   logic signed [XY_W-1:0] u_x, u_y;
   logic signed [Z_W-1:0]  u_z;
   logic [13:0]            u_rem;
   logic                   u_qbit;
   logic signed [32:0]     u_prod;
   logic signed [18:0]     mul_a;
   logic signed [13:0]     mul_b;

   logic       accept;
   logic       bad_cfg;
   angle_type  ang;
   logic       c_neg, s_neg;
   logic [16:0] c_mag, s_mag;
   logic [11:0] hw, hd;
   logic        eol, fin;
   logic [SIDE_W:0] lc_sum;
   logic [SIDE_W-1:0] div_side;
   logic signed [ACC_W-1:0] start_x, start_y;
   logic [17:0] q_mag;
   logic        q_neg;
   logic signed [ACC_W-1:0] base_x_nx, base_y_nx;

   assign accept  = req_chan.valid && ctrl.ready;
   assign bad_cfg = (box_width_ff == '0) || (box_depth_ff == '0) || (line_skip_ff == '0) ||
                    (box_width_ff > MAX_SIDE) || (box_depth_ff > MAX_SIDE);
   assign ang     = reduce_angle(angle_ff);

   assign c_neg = cos_ff[TRIG_W-1];
   assign s_neg = sin_ff[TRIG_W-1];
   assign c_mag = c_neg ? 17'(-cos_ff) : 17'(cos_ff);
   assign s_mag = s_neg ? 17'(-sin_ff) : 17'(sin_ff);
   assign hw    = walk_w_ff[SIDE_W-1:1];
   assign hd    = walk_d_ff[SIDE_W-1:1];

   // multiplier operands: four magnitudes for the corner and divides, then skip * row step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         unique case (k_ff)
            2'd0: begin mul_a = 19'({2'b0, c_mag}); mul_b = 14'({2'b0, hw}); end
            2'd1: begin mul_a = 19'({2'b0, s_mag}); mul_b = 14'({2'b0, hw}); end
            2'd2: begin mul_a = 19'({2'b0, s_mag}); mul_b = 14'({2'b0, hd}); end
            default: begin mul_a = 19'({2'b0, c_mag}); mul_b = 14'({2'b0, hd}); end
         endcase
      end else begin
         mul_a = k_ff[0] ? 19'(step_ff[1]) : 19'(step_ff[0]);
         mul_b = 14'({1'b0, walk_skip_ff});
      end
   end

   rrg_unit u_unit (
      .op        (ctrl.op),
      .x_i       (x_ff),
      .y_i       (y_ff),
      .z_i       (z_ff),
      .iter_i    (iter_ff),
      .rem_i     (rem_ff),
      .nbit_i    (dn_ff[DIV_BITS-1]),
      .divisor_i (dd_ff),
      .mul_a_i   (mul_a),
      .mul_b_i   (mul_b),
      .x_o       (u_x),
      .y_o       (u_y),
      .z_o       (u_z),
      .rem_o     (u_rem),
      .qbit_o    (u_qbit),
      .prod_o    (u_prod)
   );

   // first corner: center plus rotated (-hw, s*hd), all terms exact in q16
   always_comb begin
      start_x = ACC_W'(center_col_ff) <<< FRAC_BITS;
      start_y = ACC_W'(center_row_ff) <<< FRAC_BITS;
      start_x = c_neg ? start_x + ACC_W'(mag_ff[0]) : start_x - ACC_W'(mag_ff[0]);
      start_x = (dir_ff ^ s_neg) ? start_x + ACC_W'(mag_ff[2]) : start_x - ACC_W'(mag_ff[2]);
      start_y = s_neg ? start_y + ACC_W'(mag_ff[1]) : start_y - ACC_W'(mag_ff[1]);
      start_y = (dir_ff ^ c_neg) ? start_y - ACC_W'(mag_ff[3]) : start_y + ACC_W'(mag_ff[3]);
   end

   // divide operands and signs: row x, row y, column x, column y
   assign div_side = k_ff[1] ? walk_d_ff : walk_w_ff;
   always_comb begin
      unique case (k_ff)
         2'd0: q_neg = c_neg;
         2'd1: q_neg = s_neg;
         2'd2: q_neg = dir_ff ^ s_neg;
         default: q_neg = ~(dir_ff ^ c_neg);
      endcase
   end
   assign q_mag = {1'b0, q_ff[16:0]};

   // walk bookkeeping
   assign eol       = ({1'b0, pc_ff} + 13'd1) >= walk_d_ff;
   assign lc_sum    = {2'b0, lc_ff} + {1'b0, walk_skip_ff};
   assign fin       = eol && (lc_sum >= {1'b0, walk_w_ff});
   assign base_x_nx = base_x_ff + ACC_W'(skrs_x_ff);
   assign base_y_nx = base_y_ff + ACC_W'(skrs_y_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept && req_chan.restart && !bad_cfg) begin
                         state_in = ST_CORDIC;
                      end
         ST_CORDIC:   if (iter_ff == 5'(CORDIC_STAGES - 1)) begin
                         state_in = ST_TRIG;
                      end
         ST_TRIG:     state_in = ST_MUL;
         ST_MUL:      if (k_ff == 2'd3) begin
                         state_in = ST_START;
                      end
         ST_START:    state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN:  if (iter_ff == 5'(DIV_BITS - 1)) begin
                         state_in = (k_ff == 2'd3) ? ST_SKIP : ST_DIV_LOAD;
                      end
         ST_SKIP:     if (k_ff == 2'd1) begin
                         state_in = ST_IDLE;
                      end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl.op    = OP_NONE;
      ctrl.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:    ctrl.ready = !rsp_valid_ff || rsp_chan.ready;
         ST_CORDIC:  ctrl.op = OP_CORDIC;
         ST_MUL:     ctrl.op = OP_MUL;
         ST_SKIP:    ctrl.op = OP_MUL;
         ST_DIV_RUN: ctrl.op = OP_DIV;
         default:    ctrl.op = OP_NONE;
      endcase
   end

   assign req_chan.ready = ctrl.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
         angle_ff      <= '0;
         box_width_ff  <= 13'd1;
         box_depth_ff  <= 13'd1;
         direction_ff  <= 1'b0;
         line_skip_ff  <= 13'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_COL: center_col_ff <= csr_wdata[14:0];
            CSR_CENTER_ROW: center_row_ff <= csr_wdata[14:0];
            CSR_ANGLE:      angle_ff      <= csr_wdata;
            CSR_BOX_WIDTH:  box_width_ff  <= csr_wdata[SIDE_W-1:0];
            CSR_BOX_DEPTH:  box_depth_ff  <= csr_wdata[SIDE_W-1:0];
            CSR_DIRECTION:  direction_ff  <= csr_wdata[0];
            CSR_LINE_SKIP:  line_skip_ff  <= csr_wdata[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         k_ff         <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_CORDIC:   iter_ff <= (state_in == ST_CORDIC) ? iter_ff + 5'd1 : '0;
            ST_DIV_RUN:  iter_ff <= (state_in == ST_DIV_RUN) ? iter_ff + 5'd1 : '0;
            default:     iter_ff <= '0;
         endcase
         unique case (state_ff)
            ST_MUL, ST_DIV_RUN, ST_SKIP: begin
               if (state_in != state_ff || state_ff == ST_MUL || state_ff == ST_SKIP) begin
                  k_ff <= (state_in == ST_START || state_in == ST_IDLE ||
                           state_in == ST_SKIP && state_ff == ST_DIV_RUN) ? 2'd0 : k_ff + 2'd1;
               end
            end
            default: ;
         endcase
         if (state_ff == ST_TRIG) begin
            k_ff <= '0;
         end
         // response register, a new transaction is taken only while no result is held or the held one leaves
         if (accept && (req_chan.restart ? bad_cfg : active_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_chan.restart) begin
            active_ff <= 1'b0;
         end else if (accept && active_ff && fin) begin
            active_ff <= 1'b0;
         end else if (state_ff == ST_SKIP && state_in == ST_IDLE) begin
            active_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.restart && !bad_cfg) begin
               walk_w_ff    <= box_width_ff;
               walk_d_ff    <= box_depth_ff;
               walk_skip_ff <= line_skip_ff;
               dir_ff       <= direction_ff;
               x_ff         <= CORDIC_X0;
               y_ff         <= '0;
               z_ff         <= Z_W'(ang.r) <<< FRAC_BITS;
               neg_ff       <= ang.neg;
            end
         end
         ST_CORDIC: begin
            x_ff <= u_x;
            y_ff <= u_y;
            z_ff <= u_z;
         end
         ST_TRIG: begin
            cos_ff <= trig_round(x_ff, neg_ff);
            sin_ff <= trig_round(y_ff, neg_ff);
         end
         ST_MUL: begin
            mag_ff[k_ff] <= u_prod[MAG_W-1:0];
         end
         ST_START: begin
            base_x_ff <= start_x;
            base_y_ff <= start_y;
            cur_x_ff  <= start_x;
            cur_y_ff  <= start_y;
         end
         ST_DIV_LOAD: begin
            // round to nearest: (4*mag + side) / (2*side)
            dn_ff  <= {mag_ff[k_ff], 2'b00} + DIV_BITS'(div_side);
            dd_ff  <= {div_side, 1'b0};
            rem_ff <= '0;
            q_ff   <= '0;
         end
         ST_DIV_RUN: begin
            rem_ff <= u_rem;
            dn_ff  <= {dn_ff[DIV_BITS-2:0], 1'b0};
            q_ff   <= {q_ff[DIV_BITS-2:0], u_qbit};
            if (iter_ff == 5'(DIV_BITS - 1)) begin
               step_ff[k_ff] <= q_neg ? -{q_mag[16:0], u_qbit} : {q_mag[16:0], u_qbit};
            end
         end
         ST_SKIP: begin
            if (k_ff[0]) begin
               skrs_y_ff <= u_prod[31:0];
            end else begin
               skrs_x_ff <= u_prod[31:0];
            end
         end
         default: ;
      endcase

      // walk advance
      if (state_ff == ST_IDLE && accept && !req_chan.restart && active_ff && !fin) begin
         if (eol) begin
            lc_ff     <= lc_sum[IDX_W-1:0];
            pc_ff     <= '0;
            base_x_ff <= base_x_nx;
            base_y_ff <= base_y_nx;
            cur_x_ff  <= base_x_nx;
            cur_y_ff  <= base_y_nx;
         end else begin
            pc_ff    <= pc_ff + 12'd1;
            cur_x_ff <= cur_x_ff + ACC_W'(step_ff[2]);
            cur_y_ff <= cur_y_ff + ACC_W'(step_ff[3]);
         end
      end
      if (state_ff == ST_START) begin
         lc_ff <= '0;
         pc_ff <= '0;
      end

      // response payload
      if (accept && req_chan.restart) begin
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_line_ff   <= '0;
         rsp_point_ff  <= '0;
         rsp_eol_ff    <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_status_ff <= 1'b1;
      end else if (accept && active_ff) begin
         rsp_x_ff      <= sat32(cur_x_ff);
         rsp_y_ff      <= sat32(cur_y_ff);
         rsp_line_ff   <= lc_ff;
         rsp_point_ff  <= pc_ff;
         rsp_eol_ff    <= eol;
         rsp_last_ff   <= fin;
         rsp_status_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.point_x     = rsp_x_ff;
   assign rsp_chan.point_y     = rsp_y_ff;
   assign rsp_chan.line_index  = rsp_line_ff;
   assign rsp_chan.point_index = rsp_point_ff;
   assign rsp_chan.end_of_line = rsp_eol_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

`default_nettype wire

@@ src/rrg_unit.sv @@
// rrg_unit: shared arithmetic step (cordic rotation, restoring divide bit, small multiply)
// depends on rrg_pkg
`default_nettype none

module rrg_unit
   import rrg_pkg::*;
(
   input  wire unit_op_type            op,
   input  wire logic signed [XY_W-1:0] x_i,
   input  wire logic signed [XY_W-1:0] y_i,
   input  wire logic signed [Z_W-1:0]  z_i,
   input  wire logic [4:0]             iter_i,
   input  wire logic [13:0]            rem_i,
   input  wire logic                   nbit_i,
   input  wire logic [13:0]            divisor_i,
   input  wire logic signed [18:0]     mul_a_i,
   input  wire logic signed [13:0]     mul_b_i,
   output logic signed [XY_W-1:0]      x_o,
   output logic signed [XY_W-1:0]      y_o,
   output logic signed [Z_W-1:0]       z_o,
   output logic [13:0]                 rem_o,
   output logic                        qbit_o,
   output logic signed [32:0]          prod_o
);

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic [14:0]            rem2;
   logic [14:0]            diff;

   assign xs   = x_i >>> iter_i;
   assign ys   = y_i >>> iter_i;
   assign rem2 = {rem_i, nbit_i};
   assign diff = rem2 - {1'b0, divisor_i};

   always_comb begin
      x_o    = x_i;
      y_o    = y_i;
      z_o    = z_i;
      rem_o  = rem_i;
      qbit_o = 1'b0;
      prod_o = '0;
      unique case (op)
         OP_CORDIC: begin
            if (z_i >= 0) begin
               x_o = x_i - ys;
               y_o = y_i + xs;
               z_o = z_i - atan_entry(iter_i);
            end else begin
               x_o = x_i + ys;
               y_o = y_i - xs;
               z_o = z_i + atan_entry(iter_i);
            end
         end
         OP_DIV: begin
            if (rem2 >= {1'b0, divisor_i}) begin
               rem_o  = diff[13:0];
               qbit_o = 1'b1;
            end else begin
               rem_o  = rem2[13:0];
            end
         end
         OP_MUL: begin
            prod_o = 33'(mul_a_i) * 33'(mul_b_i);
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire
